/* rtl/core/fhc_pkg.sv */
`default_nettype none
package fhc_pkg;

  localparam int KEY_W = 32;
  localparam int SLOT_W = 8;
  localparam int HASH_W = 32;
  localparam logic [63:0] HASH_MUL = 64'h2545_F491_4F6C_DD1D;
  localparam logic [1:0] HASH_LAST_CHUNK = 2'd3;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic command;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic hit;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  function automatic logic [HASH_W-1:0] xorshift32(input logic [HASH_W-1:0] x);
    logic [HASH_W-1:0] h;
    h = x;
    h = h ^ (h << 13);
    h = h ^ (h >> 17);
    h = h ^ (h << 5);
    return h;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/fhc_ram.sv */
`default_nettype none
module fhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/fhc_hash.sv */
`default_nettype none
module fhc_hash
  import fhc_pkg::*;
#(
  parameter int NUM_BUCKETS = 512,
  localparam int BW = $clog2(NUM_BUCKETS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   done,
  output logic      [BW-1:0]     bucket
);

  localparam logic [31:0] BMASK = 32'(NUM_BUCKETS - 1);

  logic [HASH_W-1:0] h;
  logic [63:0] acc;
  logic [1:0] cnt;
  logic run;
  logic [15:0] chunk;
  logic [47:0] pp;
  logic [5:0] sh;

  // one 32x16 partial product per cycle
  assign sh = {cnt, 4'b0000};
  assign chunk = 16'(HASH_MUL >> sh);
  assign pp = 48'(h) * 48'(chunk);
  assign bucket = BW'(acc[63:32] & BMASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 2'd1;
        if (cnt == HASH_LAST_CHUNK) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      h <= xorshift32(key[HASH_W-1:0]);
      acc <= '0;
    end else if (run) begin
      acc <= acc + (64'(pp) << sh);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/fifo_hash_cache_lookup.sv */
`default_nettype none
// access: hashes the key, then walks the bucket chain slot by slot; a miss inserts the key,
// first unlinking the oldest slot once full; the hash takes 4 multiply passes
// clear: empties every bucket head (one bucket written per cycle)
// one word at a time; busy stays high until the result strobe
// reset: sweeps the bucket memory with busy high, no result
// the receiver cannot stall: done is high for exactly one cycle per word
module fifo_hash_cache_lookup
  import fhc_pkg::*;
#(
  parameter int NUM_SLOTS = 256,
  parameter int NUM_BUCKETS = 512
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int LW = (SW > BW) ? SW : BW;
  localparam int PW = LW + 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_CLEAR   = 10'b00_0000_0010,
    S_HASH    = 10'b00_0000_0100,
    S_HEAD    = 10'b00_0000_1000,
    S_WALK    = 10'b00_0001_0000,
    S_MISS    = 10'b00_0010_0000,
    S_UNLINK  = 10'b00_0100_0000,
    S_INSRD   = 10'b00_1000_0000,
    S_INSLINK = 10'b01_0000_0000,
    S_INSPREV = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;
  logic [KEY_W-1:0] key_r;
  logic [BW-1:0] b_r, b_next;
  logic [SW-1:0] idx, idx_next;
  logic [SW-1:0] fill, fill_next;
  logic full, full_next;
  logic [BW-1:0] sweep, sweep_next;
  logic clr_rsp, clr_rsp_next;
  logic done_next;
  rsp_t rsp_next;

  logic hash_load, hash_done;
  logic [BW-1:0] hash_bucket;

  logic b_we;
  logic [BW-1:0] b_waddr, b_raddr;
  logic [SW:0] b_wdata, b_rdata;
  logic k_we;
  logic [KEY_W-1:0] k_rdata;
  logic n_we;
  logic [SW-1:0] n_waddr;
  logic [SW:0] n_wdata, n_rdata;
  logic p_we;
  logic [SW-1:0] p_waddr;
  logic [PW-1:0] p_wdata, p_rdata;
  logic [SW-1:0] s_raddr;

  fhc_hash #(.NUM_BUCKETS(NUM_BUCKETS)) u_hash (
    .clk    (clk),
    .rst    (rst),
    .load   (hash_load),
    .key    (req.key),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  // bucket head: {valid, slot}
  fhc_ram #(.WIDTH(SW + 1), .DEPTH(NUM_BUCKETS)) u_head_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  fhc_ram #(.WIDTH(KEY_W), .DEPTH(NUM_SLOTS)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(fill), .wdata(key_r),
    .raddr(s_raddr), .rdata(k_rdata)
  );

  // next link: {valid, slot}
  fhc_ram #(.WIDTH(SW + 1), .DEPTH(NUM_SLOTS)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(s_raddr), .rdata(n_rdata)
  );

  // prev link: {head flag, bucket or slot}
  fhc_ram #(.WIDTH(PW), .DEPTH(NUM_SLOTS)) u_prev_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(s_raddr), .rdata(p_rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    b_next = b_r;
    idx_next = idx;
    fill_next = fill;
    full_next = full;
    sweep_next = sweep;
    clr_rsp_next = clr_rsp;
    done_next = 1'b0;
    rsp_next = rsp;
    hash_load = 1'b0;
    b_we = 1'b0;
    b_waddr = b_r;
    b_wdata = '0;
    b_raddr = b_r;
    k_we = 1'b0;
    n_we = 1'b0;
    n_waddr = fill;
    n_wdata = '0;
    p_we = 1'b0;
    p_waddr = fill;
    p_wdata = '0;
    s_raddr = idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req.command == CMD_CLEAR) begin
            state_next = S_CLEAR;
            sweep_next = '0;
            clr_rsp_next = 1'b1;
            fill_next = '0;
            full_next = 1'b0;
          end else begin
            hash_load = 1'b1;
            state_next = S_HASH;
          end
        end
      end
      S_CLEAR: begin
        b_we = 1'b1;
        b_waddr = sweep;
        sweep_next = sweep + BW'(1);
        if (sweep == LAST_BUCKET) begin
          state_next = S_IDLE;
          clr_rsp_next = 1'b0;
          if (clr_rsp) begin
            done_next = 1'b1;
            rsp_next = '{hit: 1'b0, slot: '0};
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          b_raddr = hash_bucket;
          b_next = hash_bucket;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (b_rdata[SW]) begin
          s_raddr = b_rdata[SW-1:0];
          idx_next = b_rdata[SW-1:0];
          state_next = S_WALK;
        end else begin
          state_next = S_MISS;
        end
      end
      S_WALK: begin
        if (k_rdata == key_r) begin
          done_next = 1'b1;
          rsp_next = '{hit: 1'b1, slot: SLOT_W'(idx)};
          state_next = S_IDLE;
        end else if (n_rdata[SW]) begin
          s_raddr = n_rdata[SW-1:0];
          idx_next = n_rdata[SW-1:0];
        end else begin
          state_next = S_MISS;
        end
      end
      S_MISS: begin
        s_raddr = fill;
        state_next = full ? S_UNLINK : S_INSRD;
      end
      S_UNLINK: begin
        // take the victim slot out of its chain
        if (n_rdata[SW]) begin
          p_we = 1'b1;
          p_waddr = n_rdata[SW-1:0];
          p_wdata = p_rdata;
        end
        if (p_rdata[LW]) begin
          b_we = 1'b1;
          b_waddr = BW'(p_rdata[LW-1:0]);
          b_wdata = n_rdata;
        end else begin
          n_we = 1'b1;
          n_waddr = SW'(p_rdata[LW-1:0]);
          n_wdata = n_rdata;
        end
        state_next = S_INSRD;
      end
      S_INSRD: begin
        state_next = S_INSLINK;
      end
      S_INSLINK: begin
        k_we = 1'b1;
        n_we = 1'b1;
        n_wdata = b_rdata;
        b_we = 1'b1;
        b_wdata = {1'b1, fill};
        if (b_rdata[SW]) begin
          p_we = 1'b1;
          p_waddr = b_rdata[SW-1:0];
          p_wdata = {1'b0, LW'(fill)};
        end
        state_next = S_INSPREV;
      end
      S_INSPREV: begin
        p_we = 1'b1;
        p_wdata = {1'b1, LW'(b_r)};
        done_next = 1'b1;
        rsp_next = '{hit: 1'b0, slot: SLOT_W'(fill)};
        if (fill == LAST_SLOT) begin
          fill_next = '0;
          full_next = 1'b1;
        end else begin
          fill_next = fill + SW'(1);
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      clr_rsp <= 1'b0;
      fill <= '0;
      full <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
      clr_rsp <= clr_rsp_next;
      fill <= fill_next;
      full <= full_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hash_load) begin
      key_r <= req.key;
    end
    b_r <= b_next;
    idx <= idx_next;
    rsp <= rsp_next;
  end

endmodule
`default_nettype wire
